// File: src/stok_pkg.sv
package stok_pkg;

	localparam int MAX_TOKEN_LEN = 63;
	localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);

	// Result queue depth; a power of two so the pointers wrap on their own.
	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_HIGH   = 8'h80;

	typedef enum logic [1:0] {
		KIND_WORD  = 2'd0,
		KIND_QUOTE = 2'd1,
		KIND_PUNCT = 2'd2
	} kind_t;

	typedef enum logic [4:0] {
		MODE_IDLE    = 5'b00001,
		MODE_SLASH   = 5'b00010,
		MODE_COMMENT = 5'b00100,
		MODE_QUOTE   = 5'b01000,
		MODE_WORD    = 5'b10000
	} mode_t;

	typedef struct packed {
		logic [7:0] tok_char;
		logic       tok_last;
		logic       tok_empty;
		kind_t      tok_kind;
		logic       tok_truncated;
	} tok_t;

	// Results of one step: the second one is only used when the first is.
	typedef struct packed {
		logic v0;
		tok_t r0;
		logic v1;
		tok_t r1;
	} res_pair_t;

	function automatic logic is_punct(input logic [7:0] b);
		return (b == CH_LBRACE) || (b == CH_RBRACE) || (b == CH_LPAREN) ||
			(b == CH_RPAREN) || (b == CH_SQUOTE) || (b == CH_COMMA);
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return (b <= CH_SPACE) || (b >= CH_HIGH);
	endfunction

endpackage

// File: src/stok_in_if.sv
interface stok_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

// File: src/stok_out_if.sv
interface stok_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] tok_char;
	logic       tok_last;
	logic       tok_empty;
	logic [1:0] tok_kind;
	logic       tok_truncated;

	modport source (output valid, output tok_char, output tok_last, output tok_empty,
		output tok_kind, output tok_truncated, input ready);
	modport sink (input valid, input tok_char, input tok_last, input tok_empty,
		input tok_kind, input tok_truncated, output ready);
endinterface

// File: src/stok_step.sv
module stok_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [7:0]          in_byte,
	output stok_pkg::res_pair_t res
);
	import stok_pkg::*;

	mode_t            mode_q, mode_d;
	logic [7:0]       held_q, held_d;
	logic             hvalid_q, hvalid_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic             ovf_q, ovf_d;

	// Token state as seen by this byte, after a lone slash has become a word.
	logic [7:0]       e_held;
	logic             e_valid;
	logic [LEN_W-1:0] e_len;
	logic             e_ovf;

	logic  do_append, do_finish, do_punct;
	kind_t kind;

	always_comb begin
		e_held    = held_q;
		e_valid   = hvalid_q;
		e_len     = len_q;
		e_ovf     = ovf_q;
		mode_d    = mode_q;
		do_append = 1'b0;
		do_finish = 1'b0;
		do_punct  = 1'b0;
		kind      = KIND_WORD;

		unique case (mode_q)
			MODE_IDLE: begin
				if (!is_space(in_byte)) begin
					if (in_byte == CH_SLASH) begin
						mode_d = MODE_SLASH;
					end else if (in_byte == CH_DQUOTE) begin
						mode_d = MODE_QUOTE;
					end else if (is_punct(in_byte)) begin
						do_punct = 1'b1;
					end else begin
						mode_d    = MODE_WORD;
						do_append = 1'b1;
					end
				end
			end
			MODE_SLASH: begin
				if (in_byte == CH_SLASH) begin
					mode_d = MODE_COMMENT;
				end else begin
					mode_d  = MODE_WORD;
					e_held  = CH_SLASH;
					e_valid = 1'b1;
					e_len   = LEN_W'(1);
					e_ovf   = 1'b0;
					if (is_punct(in_byte)) begin
						do_finish = 1'b1;
						do_punct  = 1'b1;
					end else if (is_space(in_byte)) begin
						do_finish = 1'b1;
					end else begin
						do_append = 1'b1;
					end
				end
			end
			MODE_COMMENT: begin
				if (in_byte == 8'h00 || in_byte == CH_NL) begin
					mode_d = MODE_IDLE;
				end
			end
			MODE_QUOTE: begin
				kind = KIND_QUOTE;
				if (in_byte == CH_DQUOTE || in_byte == 8'h00) begin
					do_finish = 1'b1;
				end else begin
					do_append = 1'b1;
				end
			end
			MODE_WORD: begin
				if (is_punct(in_byte)) begin
					do_finish = 1'b1;
					do_punct  = 1'b1;
				end else if (is_space(in_byte)) begin
					do_finish = 1'b1;
				end else begin
					do_append = 1'b1;
				end
			end
			default: begin
				mode_d = MODE_IDLE;
			end
		endcase
	end

	always_comb begin
		held_d   = e_held;
		hvalid_d = e_valid;
		len_d    = e_len;
		ovf_d    = e_ovf;
		res      = '0;

		if (do_append) begin
			if (!e_valid) begin
				held_d   = in_byte;
				hvalid_d = 1'b1;
				len_d    = LEN_W'(1);
			end else if (e_len >= LEN_W'(MAX_TOKEN_LEN)) begin
				ovf_d = 1'b1;
			end else begin
				res.v0          = 1'b1;
				res.r0.tok_char = e_held;
				res.r0.tok_kind = kind;
				held_d          = in_byte;
				len_d           = e_len + LEN_W'(1);
			end
		end

		if (do_finish) begin
			res.v0 = 1'b1;
			if (e_valid) begin
				res.r0.tok_char      = e_held;
				res.r0.tok_truncated = e_ovf;
			end else begin
				res.r0.tok_empty = 1'b1;
			end
			res.r0.tok_last = 1'b1;
			res.r0.tok_kind = kind;
			held_d   = 8'h00;
			hvalid_d = 1'b0;
			len_d    = '0;
			ovf_d    = 1'b0;
		end

		// A punctuation token follows the word it closes, or stands alone.
		if (do_punct) begin
			if (do_finish) begin
				res.v1          = 1'b1;
				res.r1.tok_char = in_byte;
				res.r1.tok_last = 1'b1;
				res.r1.tok_kind = KIND_PUNCT;
			end else begin
				res.v0          = 1'b1;
				res.r0.tok_char = in_byte;
				res.r0.tok_last = 1'b1;
				res.r0.tok_kind = KIND_PUNCT;
			end
		end

		if (do_finish || mode_d == MODE_IDLE) begin
			// Any return to idle leaves a clean token state.
			held_d   = 8'h00;
			hvalid_d = 1'b0;
			len_d    = '0;
			ovf_d    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			held_q   <= 8'h00;
			hvalid_q <= 1'b0;
			len_q    <= '0;
			ovf_q    <= 1'b0;
		end else if (fire) begin
			mode_q   <= do_finish ? MODE_IDLE : mode_d;
			held_q   <= held_d;
			hvalid_q <= hvalid_d;
			len_q    <= len_d;
			ovf_q    <= ovf_d;
		end
	end

endmodule

// File: src/stok_queue.sv
module stok_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  stok_pkg::res_pair_t res,
	output logic                room,
	stok_out_if.source          dst
);
	import stok_pkg::*;

	tok_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;
	logic             push0, push1, pop;
	tok_t             head;

	assign push0 = fire && res.v0;
	assign push1 = fire && res.v1;
	assign pop   = dst.valid && dst.ready;

	// Room for the two results that a single byte may produce.
	assign room = (count_q <= CNT_W'(QUEUE_DEPTH - 2));

	assign head              = entry_q[rd_q];
	assign dst.valid         = (count_q != '0);
	assign dst.tok_char      = head.tok_char;
	assign dst.tok_last      = head.tok_last;
	assign dst.tok_empty     = head.tok_empty;
	assign dst.tok_kind      = head.tok_kind;
	assign dst.tok_truncated = head.tok_truncated;

	always_ff @(posedge clk) begin
		if (push0) begin
			entry_q[wr_q] <= res.r0;
		end
		if (push1) begin
			entry_q[wr_q + PTR_W'(1)] <= res.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PTR_W'(push0) + PTR_W'(push1);
			rd_q    <= rd_q + PTR_W'(pop);
			count_q <= count_q + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(pop);
		end
	end

endmodule

// File: src/script_tokenizer.sv
// A result is registered into the result queue when the byte that releases it is accepted.
// Throughput: one text byte per cycle while the result queue has room for two results.
// A byte that closes a word on punctuation yields two results; the four-entry result queue
// drains one per cycle while the consumer is ready, and input is held off while fewer than
// two entries are free. Reset clears the scan state and empties the result queue at once.
module script_tokenizer (
	input  logic       clk,
	input  logic       arst_n,
	stok_in_if.sink    text,
	stok_out_if.source token
);
	import stok_pkg::*;

	logic      room;
	logic      fire;
	res_pair_t res;

	assign text.ready = room;
	assign fire       = text.valid && room;

	stok_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.in_byte (text.in_byte),
		.res     (res)
	);

	stok_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.res    (res),
		.room   (room),
		.dst    (token)
	);

endmodule
